/* hw/rtl/stereo_peak_frequency_estimator_unit_macros.svh */
// assertion macros used by the checker file
`ifndef STEREO_PEAK_FREQUENCY_ESTIMATOR_UNIT_MACROS_SVH
`define STEREO_PEAK_FREQUENCY_ESTIMATOR_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SPFE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spfe check failed");
// implication with the consequent checked in the cycle after the antecedent
`define SPFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spfe check failed");
`endif

/* hw/rtl/spfe_pkg.sv */
// shared types and constants of the peak frequency estimator
package spfe_pkg;
  localparam int MaxFrames = 65536;
  localparam int FcW = 17;
  localparam int IntervalMax = 131071;
  localparam int DivW = 34;
  localparam int DivCntW = 6;

  localparam logic [1:0] CfgThreshold = 2'd0;
  localparam logic [1:0] CfgRate = 2'd1;
  localparam logic [1:0] CfgStereo = 2'd2;
  localparam logic [1:0] CfgTarget = 2'd3;

  typedef struct packed {
    logic        result_valid;
    logic [17:0] avg_freq_left;
    logic [15:0] avg_amp_left;
    logic [17:0] avg_freq_right;
    logic [15:0] avg_amp_right;
    logic [11:0] peaks_left;
    logic [15:0] peaks_right;
  } result_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               last_frame;
  } frame_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DETECT, S_DIV_L, S_DIV_R, S_FIN, S_AVG_FL, S_AVG_AL, S_AVG_FR,
    S_AVG_AR, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;
endpackage

/* hw/rtl/spfe_stream_if.sv */
// valid/ready channel carrying one payload beat
interface spfe_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/spfe_divider.sv */
// unsigned restoring divider, one quotient bit per cycle
module spfe_divider (
  input  logic clk,
  input  logic rst,
  input  spfe_pkg::div_req_t req,
  output logic busy,
  output logic [spfe_pkg::DivW-1:0] quotient
);
  import spfe_pkg::*;
  logic [DivW-1:0] rem, quo, dvs;
  logic [DivCntW-1:0] cnt;
  logic [DivW:0] shifted, diff;

  assign shifted = {rem, quo[DivW-1]};
  assign diff = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= DivCntW'(DivW);
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!diff[DivW]) begin
        rem <= diff[DivW-1:0];
        quo <= {quo[DivW-2:0], 1'b1};
      end else begin
        rem <= shifted[DivW-1:0];
        quo <= {quo[DivW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == DivCntW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

/* hw/rtl/stereo_peak_frequency_estimator_unit.sv */
// top level of the stereo peak frequency estimator
//
//  channel  dir  beat
//  in_ch    in   left_sample, right_sample, last_frame
//  out_ch   out  seven result fields
//  cfg      in   we, index, data (one register per write)
//
// ordinary frame: accept, detect, two divide slots and finish, then back to
// ready; a counted peak stretches its slot while the shared bit-serial
// divider runs
// last frame: a wait state in S_OUT and four average divides more; it
// waits longer while the previous result is still unread
// rst is synchronous; it clears the buffer state and loads the config defaults
// in_ch ready only in idle; a result waits in the output register for ready
module stereo_peak_frequency_estimator_unit (
  input  logic clk,
  input  logic rst,
  spfe_stream_if.sink in_ch,
  spfe_stream_if.source out_ch,
  input  logic        we,
  input  logic [1:0]  index,
  input  logic [17:0] data
);
  import spfe_pkg::*;

  // configuration registers
  logic [16:0] peak_threshold;
  logic [17:0] sample_rate;
  logic        stereo_mode;
  logic [11:0] target_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold <= 17'd13107;
      sample_rate <= 18'd44100;
      stereo_mode <= 1'b1;
      target_count <= 12'd1000;
    end else if (we) begin
      case (index)
        CfgThreshold: peak_threshold <= data[16:0];
        CfgRate: sample_rate <= data;
        CfgStereo: stereo_mode <= data[0];
        CfgTarget: target_count <= data[11:0];
        default: ;
      endcase
    end
  end

  // buffer state
  logic signed [15:0] prev_l, prev2_l, trough_l, prev_r, prev2_r, trough_r;
  logic [16:0] interval_l, interval_r;
  logic [11:0] count_l;
  logic [15:0] count_r;
  logic [29:0] fsum_l;
  logic [33:0] fsum_r;
  logic signed [27:0] asum_l;
  logic signed [31:0] asum_r;
  logic [FcW:0] frame_count;
  logic done;

  frame_t cur;
  result_t res;
  logic res_valid;
  state_t state, state_next;
  logic peak_l, peak_r;

  div_req_t dreq;
  logic dbusy;
  logic [DivW-1:0] dq;
  logic dstarted;
  logic act_d;

  spfe_divider u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quotient(dq));

  // peak and trough detection on the latched frame
  logic signed [15:0] s_l, s_r;
  logic act;
  logic is_pk_l, is_tr_l, is_pk_r, is_tr_r, cnt_l_ok, cnt_r_ok;
  logic signed [17:0] diff_l, diff_r;
  assign s_l = cur.left_sample;
  assign s_r = stereo_mode ? cur.right_sample : 16'sd0;
  assign act = !done && (count_l < target_count) && (frame_count < (FcW+1)'(MaxFrames));
  assign is_pk_l = prev_l > s_l && prev_l > prev2_l;
  assign is_tr_l = prev_l < s_l && prev_l < prev2_l;
  assign is_pk_r = stereo_mode && prev_r > s_r && prev_r > prev2_r;
  assign is_tr_r = stereo_mode && prev_r < s_r && prev_r < prev2_r;
  assign diff_l = 18'(prev_l) - 18'(trough_l);
  assign diff_r = 18'(prev_r) - 18'(trough_r);
  assign cnt_l_ok = diff_l > $signed({1'b0, peak_threshold}) && interval_l != 0
                    && count_l != 12'hFFF;
  assign cnt_r_ok = diff_r > $signed({1'b0, peak_threshold}) && interval_r != 0
                    && count_r != 16'hFFFF;

  // signed averages via magnitude divide
  logic neg_l, neg_r;
  logic [31:0] mag_l, mag_r;
  assign neg_l = asum_l[27];
  assign neg_r = asum_r[31];
  assign mag_l = neg_l ? 32'(-asum_l) : 32'(asum_l);
  assign mag_r = neg_r ? 32'(-asum_r) : 32'(asum_r);

  // next state; a last frame waits in S_OUT until the result register is free
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_ch.valid) state_next = S_DETECT;
      S_DETECT: state_next = S_DIV_L;
      S_DIV_L: if (!peak_l || (dstarted && !dbusy)) state_next = S_DIV_R;
      S_DIV_R: if (!peak_r || (dstarted && !dbusy)) state_next = S_FIN;
      S_FIN: state_next = cur.last_frame ? S_OUT : S_IDLE;
      S_OUT: if (!res_valid) state_next = S_AVG_FL;
      S_AVG_FL: if (dstarted && !dbusy) state_next = S_AVG_AL;
      S_AVG_AL: if (dstarted && !dbusy) state_next = S_AVG_FR;
      S_AVG_FR: if (dstarted && !dbusy) state_next = S_AVG_AR;
      S_AVG_AR: if (dstarted && !dbusy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    dreq = '0;
    in_ch.ready = (state == S_IDLE);
    case (state)
      S_DIV_L: begin
        dreq.start = peak_l && !dstarted;
        dreq.dividend = DivW'(sample_rate);
        dreq.divisor = DivW'(interval_l);
      end
      S_DIV_R: begin
        dreq.start = peak_r && !dstarted;
        dreq.dividend = DivW'(sample_rate);
        dreq.divisor = DivW'(interval_r);
      end
      S_AVG_FL: begin
        dreq.start = !dstarted;
        dreq.dividend = DivW'(fsum_l);
        dreq.divisor = DivW'(count_l);
      end
      S_AVG_AL: begin
        dreq.start = !dstarted;
        dreq.dividend = DivW'(mag_l);
        dreq.divisor = DivW'(count_l);
      end
      S_AVG_FR: begin
        dreq.start = !dstarted;
        dreq.dividend = fsum_r;
        dreq.divisor = DivW'(count_r);
      end
      S_AVG_AR: begin
        dreq.start = !dstarted;
        dreq.dividend = DivW'(mag_r);
        dreq.divisor = DivW'(count_r);
      end
      default: ;
    endcase
  end

  assign out_ch.valid = res_valid;
  assign out_ch.payload = res;

  logic fin_ok;
  assign fin_ok = frame_count > (FcW+1)'(target_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      dstarted <= 1'b0;
      prev_l <= '0; prev2_l <= '0; trough_l <= '0; interval_l <= '0;
      prev_r <= '0; prev2_r <= '0; trough_r <= '0; interval_r <= '0;
      count_l <= '0; count_r <= '0; fsum_l <= '0; fsum_r <= '0;
      asum_l <= '0; asum_r <= '0; frame_count <= '0; done <= 1'b0;
      peak_l <= 1'b0; peak_r <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && out_ch.ready) res_valid <= 1'b0;
      dstarted <= (state_next == state) ? (dstarted || dreq.start) : 1'b0;
      case (state)
        S_IDLE: if (in_ch.valid) cur <= in_ch.payload;
        S_DETECT: begin
          peak_l <= 1'b0;
          peak_r <= 1'b0;
          if (act) begin
            if (is_pk_l) begin
              if (cnt_l_ok) begin
                peak_l <= 1'b1;
                asum_l <= asum_l + 28'(prev_l);
                count_l <= count_l + 1'b1;
              end
            end else if (is_tr_l) trough_l <= prev_l;
            if (is_pk_r) begin
              if (cnt_r_ok) begin
                peak_r <= 1'b1;
                asum_r <= asum_r + 32'(prev_r);
                count_r <= count_r + 1'b1;
              end
            end else if (is_tr_r) trough_r <= prev_r;
            prev2_l <= prev_l; prev_l <= s_l;
            prev2_r <= prev_r; prev_r <= s_r;
          end
        end
        S_DIV_L: if (state_next != state) begin
          if (peak_l) begin
            fsum_l <= fsum_l + 30'(dq);
            interval_l <= 17'd1;
          end else if (act_d && interval_l != 17'(IntervalMax))
            interval_l <= interval_l + 1'b1;
        end
        S_DIV_R: if (state_next != state) begin
          if (peak_r) begin
            fsum_r <= fsum_r + dq;
            interval_r <= 17'd1;
          end else if (act_d && interval_r != 17'(IntervalMax))
            interval_r <= interval_r + 1'b1;
        end
        S_FIN: begin
          if (count_l >= target_count) done <= 1'b1;
          if (frame_count < (FcW+1)'(MaxFrames)) frame_count <= frame_count + 1'b1;
        end
        S_AVG_FL: if (state_next != state)
          res.avg_freq_left <= (fin_ok && count_l != 0) ? dq[17:0] : '0;
        S_AVG_AL: if (state_next != state)
          res.avg_amp_left <= (fin_ok && count_l != 0) ?
                              (neg_l ? 16'(-dq[15:0]) : dq[15:0]) : '0;
        S_AVG_FR: if (state_next != state)
          res.avg_freq_right <= (fin_ok && count_r != 0) ? dq[17:0] : '0;
        S_AVG_AR: if (state_next != state) begin
          res.avg_amp_right <= (fin_ok && count_r != 0) ?
                               (neg_r ? 16'(-dq[15:0]) : dq[15:0]) : '0;
          res.result_valid <= fin_ok;
          res.peaks_left <= fin_ok ? count_l : '0;
          res.peaks_right <= fin_ok ? count_r : '0;
          res_valid <= 1'b1;
          prev_l <= '0; prev2_l <= '0; trough_l <= '0; interval_l <= '0;
          prev_r <= '0; prev2_r <= '0; trough_r <= '0; interval_r <= '0;
          count_l <= '0; count_r <= '0; fsum_l <= '0; fsum_r <= '0;
          asum_l <= '0; asum_r <= '0; frame_count <= '0; done <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // analysis window captured at detect, before the count moves
  always_ff @(posedge clk) begin
    if (rst) act_d <= 1'b0;
    else if (state == S_DETECT) act_d <= act;
  end
endmodule

/* hw/rtl/spfe_checker.sv */
// port-level checks on the estimator, bound to the top level
`include "stereo_peak_frequency_estimator_unit_macros.svh"
module spfe_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_result_valid,
  input logic [11:0] out_peaks_left,
  input logic [15:0] out_peaks_right
);
  `SPFE_ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid)
  `SPFE_ASSERT_NEXT(a_no_accept_after_frame, clk, rst, in_valid && in_ready, !in_ready)
  `SPFE_ASSERT_IMP(a_invalid_zero, clk, rst, out_valid && !out_result_valid,
    out_peaks_left == 12'd0 && out_peaks_right == 16'd0)
endmodule

bind stereo_peak_frequency_estimator_unit spfe_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result_valid(out_ch.payload.result_valid),
  .out_peaks_left(out_ch.payload.peaks_left),
  .out_peaks_right(out_ch.payload.peaks_right)
);

/* tb/stereo_peak_frequency_estimator_unit_tb.sv */
// self-checking testbench for the stereo peak frequency estimator
`timescale 1ns / 1ps
module stereo_peak_frequency_estimator_unit_tb;
  import spfe_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic we = 1'b0;
  logic [1:0] index = CfgThreshold;
  logic [17:0] data = '0;

  spfe_stream_if #(.payload_t(frame_t)) in_if ();
  spfe_stream_if #(.payload_t(result_t)) out_if ();

  stereo_peak_frequency_estimator_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_if.sink), .out_ch(out_if.source),
    .we(we), .index(index), .data(data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model copy of the registers
  int thr_reg, rate_reg, stereo_reg, target_reg;
  // per-channel buffer state, index 0 is left, 1 is right
  int prev_s[2], prev2_s[2], trough_s[2], intv[2], peaks[2];
  longint freq_acc[2], amp_acc[2];
  int frames_seen;
  bit window_closed;

  result_t pending_results[$];
  int mismatches = 0;
  longint cycles = 0;
  bit no_gaps = 1'b0;      // sender offers back to back
  bit long_hold = 1'b0;    // receiver holds off for a long stretch

  function automatic void clear_buffer_state();
    for (int c = 0; c < 2; c++) begin
      prev_s[c] = 0; prev2_s[c] = 0; trough_s[c] = 0; intv[c] = 0; peaks[c] = 0;
      freq_acc[c] = 0; amp_acc[c] = 0;
    end
    frames_seen = 0;
    window_closed = 1'b0;
  endfunction

  // one channel: peak and trough search over three samples
  function automatic void track_channel(int c, int s, bit detect);
    int cap;
    cap = (c == 0) ? 4095 : 65535;
    if (detect) begin
      if (prev_s[c] > s && prev_s[c] > prev2_s[c]) begin
        if (prev_s[c] - trough_s[c] > thr_reg && intv[c] > 0 && peaks[c] < cap) begin
          freq_acc[c] += rate_reg / intv[c];
          amp_acc[c] += prev_s[c];
          intv[c] = 0;
          peaks[c]++;
        end
      end else if (prev_s[c] < s && prev_s[c] < prev2_s[c]) begin
        trough_s[c] = prev_s[c];
      end
    end
    if (intv[c] < IntervalMax) intv[c]++;
    prev2_s[c] = prev_s[c];
    prev_s[c] = s;
  endfunction

  // advance the model by one frame, returns 1 with the result on a last frame
  function automatic bit estimate_frame(frame_t f, output result_t r);
    int smp[2];
    longint q;
    r = '0;
    smp[0] = f.left_sample;
    smp[1] = stereo_reg ? int'(f.right_sample) : 0;
    if (!window_closed && peaks[0] < target_reg && frames_seen < MaxFrames) begin
      track_channel(0, smp[0], 1'b1);
      track_channel(1, smp[1], stereo_reg != 0);
    end
    if (peaks[0] >= target_reg) window_closed = 1'b1;
    if (frames_seen < MaxFrames) frames_seen++;
    if (!f.last_frame) return 1'b0;
    if (frames_seen > target_reg) begin
      r.result_valid = 1'b1;
      if (peaks[0] > 0) begin
        q = freq_acc[0] / peaks[0]; r.avg_freq_left = q[17:0];
        q = amp_acc[0] / peaks[0];  r.avg_amp_left = q[15:0];
      end
      if (peaks[1] > 0) begin
        q = freq_acc[1] / peaks[1]; r.avg_freq_right = q[17:0];
        q = amp_acc[1] / peaks[1];  r.avg_amp_right = q[15:0];
      end
      r.peaks_left = peaks[0][11:0];
      r.peaks_right = peaks[1][15:0];
    end
    clear_buffer_state();
    return 1'b1;
  endfunction

  // one frame beat; valid stays high across back-to-back beats
  task automatic send_frame(frame_t f, bit typed, result_t typed_res);
    int gap;
    result_t r;
    gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= f;
    do @(posedge clk); while (!in_if.ready);
    if (estimate_frame(f, r)) pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // all four registers in one burst, only while idle
  task automatic set_config(int thr, int rate, int st, int tgt);
    we <= 1'b1; index <= CfgThreshold; data <= 18'(thr); @(posedge clk);
    index <= CfgRate; data <= 18'(rate); @(posedge clk);
    index <= CfgStereo; data <= 18'(st); @(posedge clk);
    index <= CfgTarget; data <= 18'(tgt); @(posedge clk);
    we <= 1'b0;
    thr_reg = thr & 17'h1FFFF; rate_reg = rate & 18'h3FFFF;
    stereo_reg = st & 1; target_reg = tgt & 12'hFFF;
  endtask

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // triangle waves with noise, sometimes plain random samples
  task automatic send_buffer(int len);
    int per_l, per_r, amp_l, amp_r, nz, ph, tl, tr;
    bit raw;
    frame_t f;
    per_l = $urandom_range(2, 24); per_r = $urandom_range(2, 24);
    amp_l = $urandom_range(0, 32767); amp_r = $urandom_range(0, 32767);
    nz = $urandom_range(0, 2000);
    raw = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < len; i++) begin
      ph = i % per_l;
      tl = (ph < per_l / 2) ? ph : per_l - ph;
      ph = i % per_r;
      tr = (ph < per_r / 2) ? ph : per_r - ph;
      if (raw) begin
        f.left_sample = 16'($urandom);
        f.right_sample = 16'($urandom);
      end else begin
        f.left_sample = clamp16(amp_l * (4 * tl - per_l) / per_l +
                                int'($urandom_range(0, 2 * nz)) - nz);
        f.right_sample = clamp16(amp_r * (4 * tr - per_r) / per_r +
                                 int'($urandom_range(0, 2 * nz)) - nz);
      end
      f.last_frame = (i == len - 1);
      send_frame(f, 1'b0, '0);
    end
  endtask

  typedef struct {
    logic signed [15:0] l;
    logic signed [15:0] r;
    bit last;
    bit typed;
    result_t res;
  } stim_row_t;

  // under reset settings no buffer this short is valid, so all results read zero
  stim_row_t directed[] = '{
    '{16'sh7FFF, 16'sh8000, 1, 1, '0},
    '{16'sh8000, 16'sh7FFF, 1, 1, '0},
    '{16'sh0000, 16'sh0000, 0, 0, '0},
    '{16'sh7FFF, 16'sh7FFF, 0, 0, '0},
    '{16'sh8000, 16'sh8000, 0, 0, '0},
    '{16'sh7FFF, 16'sh7FFF, 0, 0, '0},
    '{16'sh0000, 16'sh0000, 1, 1, '0},
    '{16'sh5555, 16'shAAAA, 1, 1, '0}
  };

  // result checker
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_if.payload);
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (out_if.payload !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p actual %p",
                                         e, out_if.payload);
        end
      end
    end
  end

  // receiver: random hold-offs, long ones while long_hold is set
  initial begin
    int n;
    out_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      n = long_hold ? 400 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18));
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    frame_t f;
    int items;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    thr_reg = 13107; rate_reg = 44100; stereo_reg = 1; target_reg = 1000;
    clear_buffer_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows under the reset settings
    foreach (directed[i]) begin
      f.left_sample = directed[i].l;
      f.right_sample = directed[i].r;
      f.last_frame = directed[i].last;
      send_frame(f, directed[i].typed, directed[i].res);
    end
    drain();

    // lowest threshold, fastest rate, single peak target
    set_config(0, 192000, 1, 1);
    send_buffer(6);
    send_buffer(2);
    send_buffer(1);
    drain();

    // highest threshold and target, slowest nonzero rate, mono
    set_config(131071, 1, 0, 4095);
    send_buffer(20);
    drain();

    // zero rate gives zero frequency
    set_config(0, 0, 1, 3);
    send_buffer(30);
    drain();

    // longer buffer sent back to back at the top threshold and target
    set_config(131071, 44100, 1, 4095);
    no_gaps = 1'b1;
    send_buffer(60);
    no_gaps = 1'b0;
    drain();

    // receiver stalls while frames keep coming, so input backs up
    set_config(100, 48000, 1, 2);
    long_hold = 1'b1;
    no_gaps = 1'b1;
    for (int b = 0; b < 4; b++) send_buffer(4);
    long_hold = 1'b0;
    no_gaps = 1'b0;
    drain();

    // random settings and buffers
    items = 0;
    while (items < 450) begin
      set_config($urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) :
                   $urandom_range(0, 20000),
                 $urandom_range(1, 192000), $urandom_range(0, 1),
                 $urandom_range(0, 4) == 0 ? $urandom_range(1, 4095) :
                   $urandom_range(1, 12));
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int b = 0; b < 4; b++) begin
        int len;
        len = target_reg < 40 ? target_reg + $urandom_range(0, 30) - 2 :
                                $urandom_range(1, 40);
        if (len < 1) len = 1;
        send_buffer(len);
        items += len;
      end
      no_gaps = 1'b0;
      drain();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
